// ===== hw/rtl/slx_pkg.sv =====
// Shared types, token codes, keyword table and character-class helpers
// for the source code lexer. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package slx_pkg;

   // Field widths of the token beat
   localparam int KIND_W = 6;
   localparam int MANT_W = 63;
   localparam int FRAC_W = 6;
   localparam int POS_W  = 32;
   localparam int LEN_W  = 16;

   localparam logic [MANT_W-1:0] MANT_MAX = '1;
   localparam logic [FRAC_W-1:0] FRAC_MAX = '1;
   localparam logic [LEN_W-1:0]  LEN_MAX  = '1;

   // Keyword prefix depth on the top level
   localparam int KEYWORD_MAX_LEN_DEFAULT = 5;

   // Token queue depth, a power of two of at least four
   localparam int FIFO_DEPTH = 4;

   // ASCII case bit for lower-casing letters
   localparam logic [7:0] CASE_BIT = 8'h20;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_NUM,
      MODE_WORD,
      MODE_OP
   } lex_mode_type;

   typedef enum logic [KIND_W-1:0] {
      TOK_INT,
      TOK_DECIMAL,
      TOK_IDENT,
      TOK_KW_IF,
      TOK_KW_WHILE,
      TOK_KW_FOR,
      TOK_KW_ELSE,
      TOK_KW_FUNC,
      TOK_KW_VAR,
      TOK_PLUS,
      TOK_MINUS,
      TOK_SLASH,
      TOK_STAR,
      TOK_ASSIGN,
      TOK_EQ,
      TOK_NE,
      TOK_LE,
      TOK_GE,
      TOK_GT,
      TOK_LT,
      TOK_LAND,
      TOK_LOR,
      TOK_BOR,
      TOK_BAND,
      TOK_SHL,
      TOK_SHR,
      TOK_PERCENT,
      TOK_BANG,
      TOK_LPAREN,
      TOK_RPAREN,
      TOK_LBRACE,
      TOK_RBRACE,
      TOK_SEMI,
      TOK_COMMA,
      TOK_ERROR,
      TOK_END
   } token_kind_type;

   // Operator and punctuation lookups answer this when nothing matches
   localparam token_kind_type KIND_NONE = TOK_INT;

   typedef struct packed {
      token_kind_type    kind;
      logic [MANT_W-1:0] mantissa;
      logic [FRAC_W-1:0] frac_digits;
      logic [POS_W-1:0]  start_pos;
      logic [LEN_W-1:0]  length;
      logic              last;
   } token_type;

   // Tokens produced by one source beat, in order
   typedef struct packed {
      logic [1:0] count;
      token_type  tok0;
      token_type  tok1;
   } push_type;

   // Keyword table; text is right-justified, first character in the top byte of its text
   localparam int KW_COUNT    = 6;
   localparam int KW_TEXT_LEN = 8;
   localparam logic [8*KW_TEXT_LEN-1:0] KW_TEXT [KW_COUNT] =
      '{"if", "while", "for", "else", "func", "var"};
   localparam int KW_LEN [KW_COUNT] = '{2, 5, 3, 4, 4, 3};
   localparam token_kind_type KW_KIND [KW_COUNT] =
      '{TOK_KW_IF, TOK_KW_WHILE, TOK_KW_FOR, TOK_KW_ELSE, TOK_KW_FUNC, TOK_KW_VAR};

   // Character i of keyword k, zero past its end
   function automatic logic [7:0] kw_byte(input int k, input int i);
      logic [8*KW_TEXT_LEN-1:0] sh;
      sh = '0;
      if (i < KW_LEN[k]) begin
         sh = KW_TEXT[k] >> (8 * (KW_LEN[k] - 1 - i));
      end
      return sh[7:0];
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_upper(input logic [7:0] c);
      return (c >= "A") && (c <= "Z");
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return is_upper(c) || ((c >= "a") && (c <= "z"));
   endfunction

   function automatic logic is_word_char(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || (c == "_");
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == " ") || (c == "\n");
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return is_upper(c) ? (c | CASE_BIT) : c;
   endfunction

   function automatic token_kind_type single_op(input logic [7:0] c);
      token_kind_type k;
      unique case (c)
         "+":     k = TOK_PLUS;
         "-":     k = TOK_MINUS;
         "/":     k = TOK_SLASH;
         "*":     k = TOK_STAR;
         "=":     k = TOK_ASSIGN;
         ">":     k = TOK_GT;
         "<":     k = TOK_LT;
         "|":     k = TOK_BOR;
         "&":     k = TOK_BAND;
         "%":     k = TOK_PERCENT;
         "!":     k = TOK_BANG;
         default: k = KIND_NONE;
      endcase
      return k;
   endfunction

   function automatic token_kind_type punct_kind(input logic [7:0] c);
      token_kind_type k;
      unique case (c)
         "(":     k = TOK_LPAREN;
         ")":     k = TOK_RPAREN;
         "{":     k = TOK_LBRACE;
         "}":     k = TOK_RBRACE;
         ";":     k = TOK_SEMI;
         ",":     k = TOK_COMMA;
         default: k = KIND_NONE;
      endcase
      return k;
   endfunction

   // Two-character operator from a pending first character and the next one
   function automatic token_kind_type pair_op(input logic [7:0] a, input logic [7:0] b);
      token_kind_type k;
      k = KIND_NONE;
      if (b == "=") begin
         if (a == "=")      k = TOK_EQ;
         else if (a == "!") k = TOK_NE;
         else if (a == "<") k = TOK_LE;
         else if (a == ">") k = TOK_GE;
      end
      if (a == b) begin
         if (a == "&")      k = TOK_LAND;
         else if (a == "|") k = TOK_LOR;
         else if (a == "<") k = TOK_SHL;
         else if (a == ">") k = TOK_SHR;
      end
      return k;
   endfunction

   function automatic logic is_sep(input logic [7:0] c);
      return (single_op(c) != KIND_NONE) || (punct_kind(c) != KIND_NONE) || is_space(c);
   endfunction

   function automatic logic [LEN_W-1:0] sat_inc16(input logic [LEN_W-1:0] v);
      return (v == LEN_MAX) ? LEN_MAX : v + LEN_W'(1);
   endfunction

   function automatic token_type make_token(input token_kind_type kind,
                                            input logic [MANT_W-1:0] mant,
                                            input logic [FRAC_W-1:0] frac,
                                            input logic [POS_W-1:0]  start,
                                            input logic [LEN_W-1:0]  len);
      token_type t;
      t.kind        = kind;
      t.mantissa    = mant;
      t.frac_digits = frac;
      t.start_pos   = start;
      t.length      = len;
      t.last        = 1'b0;
      return t;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/slx_core.sv =====
// Lexer core: source beat register, scanner state and token build.
// Depends on slx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slx_core #(
   parameter int KEYWORD_MAX_LEN = slx_pkg::KEYWORD_MAX_LEN_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [7:0]        req_char_byte,
   input  wire logic              req_is_end,
   input  wire logic              fifo_room,
   output slx_pkg::push_type      push
);

   localparam int PREFIX_W = 8 * KEYWORD_MAX_LEN;

   // Source beat register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] char_ff;
   logic       end_ff;

   // Scanner state
   slx_pkg::lex_mode_type                mode_ff, mode_in;
   logic [slx_pkg::MANT_W-1:0]           acc_ff, acc_in;
   logic                                 seen_ff, seen_in;
   logic [slx_pkg::FRAC_W-1:0]           frac_ff, frac_in;
   logic [PREFIX_W-1:0]                  prefix_ff, prefix_in;
   logic [slx_pkg::LEN_W-1:0]            wlen_ff, wlen_in;
   logic [slx_pkg::POS_W-1:0]            pos_ff, pos_in;
   logic [slx_pkg::POS_W-1:0]            start_ff, start_in;
   logic [7:0]                           pend_ff, pend_in;

   logic                    consume;
   logic                    accept;
   logic                    kw_hit;
   slx_pkg::token_kind_type kw_kind;

   // Process the held beat once the queue can take two tokens
   assign consume   = in_valid_ff && fifo_room;
   assign req_stall = in_valid_ff && !fifo_room;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in = accept ? 1'b1 : (consume ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (accept) begin
         char_ff <= req_char_byte;
         end_ff  <= req_is_end;
      end
   end

   // Match the collected word against the keyword table
   always_comb begin : kw_match
      logic kw_ok;
      kw_hit  = 1'b0;
      kw_kind = slx_pkg::TOK_IDENT;
      for (int k = 0; k < slx_pkg::KW_COUNT; k++) begin
         kw_ok = (slx_pkg::LEN_W'(slx_pkg::KW_LEN[k]) == wlen_ff) &&
                 (slx_pkg::KW_LEN[k] <= KEYWORD_MAX_LEN);
         for (int i = 0; i < KEYWORD_MAX_LEN; i++) begin
            if (prefix_ff[8*i +: 8] != slx_pkg::kw_byte(k, i)) begin
               kw_ok = 1'b0;
            end
         end
         if (kw_ok && !kw_hit) begin
            kw_hit  = 1'b1;
            kw_kind = slx_pkg::KW_KIND[k];
         end
      end
   end

   // Next state and tokens for the held beat
   always_comb begin : scan
      slx_pkg::token_type         tok [2];
      slx_pkg::token_type         num_tok;
      slx_pkg::token_type         word_tok;
      logic [1:0]                 cnt;
      logic                       do_idle;
      logic [7:0]                 lc;
      logic [7:0]                 digit;
      logic [slx_pkg::MANT_W+3:0] ext;
      logic [slx_pkg::MANT_W+3:0] sum;
      slx_pkg::token_kind_type    pk;

      mode_in   = mode_ff;
      acc_in    = acc_ff;
      seen_in   = seen_ff;
      frac_in   = frac_ff;
      prefix_in = prefix_ff;
      wlen_in   = wlen_ff;
      pos_in    = pos_ff;
      start_in  = start_ff;
      pend_in   = pend_ff;
      tok[0]    = '0;
      tok[1]    = '0;
      cnt       = 2'd0;
      do_idle   = 1'b0;

      lc    = slx_pkg::to_lower(char_ff);
      digit = char_ff - 8'("0");
      ext   = {4'b0, acc_ff};
      sum   = (ext << 3) + (ext << 1) + (slx_pkg::MANT_W+4)'(digit);
      pk    = slx_pkg::pair_op(pend_ff, char_ff);

      num_tok = slx_pkg::make_token(seen_ff ? slx_pkg::TOK_DECIMAL : slx_pkg::TOK_INT,
                                    acc_ff, seen_ff ? frac_ff : '0, start_ff, wlen_ff);
      word_tok = slx_pkg::make_token(slx_pkg::TOK_IDENT, '0, '0, start_ff, wlen_ff);

      if (consume) begin
         if (end_ff) begin
            // Flush the open token, then close the stream
            unique case (mode_ff)
               slx_pkg::MODE_NUM: begin
                  tok[cnt[0]] = num_tok;
                  cnt = cnt + 2'd1;
               end
               slx_pkg::MODE_WORD: begin
                  word_tok.kind = kw_kind;
                  tok[cnt[0]] = word_tok;
                  cnt = cnt + 2'd1;
               end
               slx_pkg::MODE_OP: begin
                  tok[cnt[0]] = slx_pkg::make_token(slx_pkg::single_op(pend_ff), '0, '0,
                                                    start_ff, slx_pkg::LEN_W'(1));
                  cnt = cnt + 2'd1;
               end
               default: ;
            endcase
            tok[cnt[0]] = slx_pkg::make_token(slx_pkg::TOK_END, '0, '0, pos_ff, '0);
            cnt       = cnt + 2'd1;
            mode_in   = slx_pkg::MODE_IDLE;
            acc_in    = '0;
            seen_in   = 1'b0;
            frac_in   = '0;
            prefix_in = '0;
            wlen_in   = '0;
            start_in  = '0;
            pend_in   = '0;
            pos_in    = '0;
         end else begin
            unique case (mode_ff)
               slx_pkg::MODE_NUM: begin
                  if (slx_pkg::is_digit(char_ff)) begin
                     // Accumulate, sticking at the top value
                     if (sum > (slx_pkg::MANT_W+4)'(slx_pkg::MANT_MAX)) begin
                        acc_in = slx_pkg::MANT_MAX;
                     end else begin
                        acc_in = sum[slx_pkg::MANT_W-1:0];
                     end
                     if (seen_ff && (frac_ff != slx_pkg::FRAC_MAX)) begin
                        frac_in = frac_ff + slx_pkg::FRAC_W'(1);
                     end
                     wlen_in = slx_pkg::sat_inc16(wlen_ff);
                  end else if ((char_ff == ".") && !seen_ff) begin
                     seen_in = 1'b1;
                     wlen_in = slx_pkg::sat_inc16(wlen_ff);
                  end else if (slx_pkg::is_sep(char_ff)) begin
                     tok[cnt[0]] = num_tok;
                     cnt     = cnt + 2'd1;
                     do_idle = 1'b1;
                  end else begin
                     // Bad character swallows the number with it
                     tok[cnt[0]] = slx_pkg::make_token(slx_pkg::TOK_ERROR, '0, '0, start_ff,
                                                       slx_pkg::sat_inc16(wlen_ff));
                     cnt     = cnt + 2'd1;
                     mode_in = slx_pkg::MODE_IDLE;
                  end
               end
               slx_pkg::MODE_WORD: begin
                  if (slx_pkg::is_word_char(char_ff)) begin
                     for (int i = 0; i < KEYWORD_MAX_LEN; i++) begin
                        if (wlen_ff == slx_pkg::LEN_W'(i)) begin
                           prefix_in[8*i +: 8] = prefix_ff[8*i +: 8] | lc;
                        end
                     end
                     wlen_in = slx_pkg::sat_inc16(wlen_ff);
                  end else begin
                     // Keyword only when a separator ends the word
                     if (slx_pkg::is_sep(char_ff)) begin
                        word_tok.kind = kw_kind;
                     end
                     tok[cnt[0]] = word_tok;
                     cnt     = cnt + 2'd1;
                     do_idle = 1'b1;
                  end
               end
               slx_pkg::MODE_OP: begin
                  if (pk != slx_pkg::KIND_NONE) begin
                     tok[cnt[0]] = slx_pkg::make_token(pk, '0, '0, start_ff,
                                                       slx_pkg::LEN_W'(2));
                     cnt     = cnt + 2'd1;
                     mode_in = slx_pkg::MODE_IDLE;
                  end else begin
                     tok[cnt[0]] = slx_pkg::make_token(slx_pkg::single_op(pend_ff), '0, '0,
                                                       start_ff, slx_pkg::LEN_W'(1));
                     cnt     = cnt + 2'd1;
                     do_idle = 1'b1;
                  end
               end
               slx_pkg::MODE_IDLE: begin
                  do_idle = 1'b1;
               end
               default: ;
            endcase

            // Start a fresh token on the current character
            if (do_idle) begin
               mode_in = slx_pkg::MODE_IDLE;
               if (!slx_pkg::is_space(char_ff)) begin
                  start_in = pos_ff;
                  if (slx_pkg::is_digit(char_ff)) begin
                     mode_in = slx_pkg::MODE_NUM;
                     acc_in  = slx_pkg::MANT_W'(digit);
                     seen_in = 1'b0;
                     frac_in = '0;
                     wlen_in = slx_pkg::LEN_W'(1);
                  end else if (slx_pkg::is_word_char(char_ff)) begin
                     mode_in   = slx_pkg::MODE_WORD;
                     prefix_in = PREFIX_W'(lc);
                     wlen_in   = slx_pkg::LEN_W'(1);
                  end else if (slx_pkg::single_op(char_ff) != slx_pkg::KIND_NONE) begin
                     mode_in = slx_pkg::MODE_OP;
                     pend_in = char_ff;
                  end else if (slx_pkg::punct_kind(char_ff) != slx_pkg::KIND_NONE) begin
                     tok[cnt[0]] = slx_pkg::make_token(slx_pkg::punct_kind(char_ff), '0, '0,
                                                       pos_ff, slx_pkg::LEN_W'(1));
                     cnt = cnt + 2'd1;
                  end else begin
                     tok[cnt[0]] = slx_pkg::make_token(slx_pkg::TOK_ERROR, '0, '0,
                                                       pos_ff, slx_pkg::LEN_W'(1));
                     cnt = cnt + 2'd1;
                  end
               end
            end
            pos_in = pos_ff + slx_pkg::POS_W'(1);
         end
      end

      // Mark the final token of this beat
      if (cnt == 2'd1) begin
         tok[0].last = 1'b1;
      end
      if (cnt == 2'd2) begin
         tok[1].last = 1'b1;
      end

      push.count = cnt;
      push.tok0  = tok[0];
      push.tok1  = tok[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= slx_pkg::MODE_IDLE;
         acc_ff    <= '0;
         seen_ff   <= 1'b0;
         frac_ff   <= '0;
         prefix_ff <= '0;
         wlen_ff   <= '0;
         pos_ff    <= '0;
         start_ff  <= '0;
         pend_ff   <= '0;
      end else begin
         mode_ff   <= mode_in;
         acc_ff    <= acc_in;
         seen_ff   <= seen_in;
         frac_ff   <= frac_in;
         prefix_ff <= prefix_in;
         wlen_ff   <= wlen_in;
         pos_ff    <= pos_in;
         start_ff  <= start_in;
         pend_ff   <= pend_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/slx_token_fifo.sv =====
// Token queue between the lexer core and the result channel.
// Takes up to two tokens a cycle, gives one while rsp_stall is low. Depends on slx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slx_token_fifo (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire slx_pkg::push_type  push,
   output logic                    room,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output slx_pkg::token_type      head
);

   localparam int DEPTH = slx_pkg::FIFO_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   slx_pkg::token_type mem [DEPTH];
   logic [PTR_W-1:0]   wptr_ff, wptr_in;
   logic [PTR_W-1:0]   rptr_ff, rptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               pop;

   // Room for a full beat's worth of tokens
   assign room      = count_ff <= CNT_W'(DEPTH - 2);
   assign rsp_valid = count_ff != '0;
   assign pop       = rsp_valid && !rsp_stall;
   assign head      = mem[rptr_ff];

   assign wptr_in  = wptr_ff + PTR_W'(push.count);
   assign rptr_in  = rptr_ff + PTR_W'(pop);
   assign count_in = count_ff + CNT_W'(push.count) - CNT_W'(pop);

   // Store incoming tokens in order
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wptr_ff] <= push.tok0;
      end
      if (push.count == 2'd2) begin
         mem[wptr_ff + PTR_W'(1)] <= push.tok1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/source_code_lexer.sv =====
// Top level of the source code lexer: core plus token queue.
// Depends on slx_pkg, slx_core and slx_token_fifo.
//
//   channel | direction | handshake             | beat
//   req_    | in        | req_valid / req_stall | one source byte or end marker
//   rsp_    | out       | rsp_valid / rsp_stall | one token
//
// A source beat is registered and processed once the queue has room, and its
// zero, one or two tokens enter a four-entry token queue; a beat can be
// taken every cycle that req_stall is low. Each token costs one result beat,
// so a beat that closes one token and emits another (the ";" of "a;") costs
// two result beats; the queue's single read port sets this.
// Reset clears the scanner state and empties the queue at once.
// req_stall rises while the held beat waits for two free queue slots, which
// happens only when rsp_stall backs the queue up.
`timescale 1ns / 1ps
`default_nettype none

module source_code_lexer #(
   parameter int KEYWORD_MAX_LEN = slx_pkg::KEYWORD_MAX_LEN_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [7:0]                   req_char_byte,
   input  wire logic                         req_is_end,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [slx_pkg::KIND_W-1:0]        rsp_token_kind,
   output logic [slx_pkg::MANT_W-1:0]        rsp_mantissa,
   output logic [slx_pkg::FRAC_W-1:0]        rsp_frac_digits,
   output logic [slx_pkg::POS_W-1:0]         rsp_start_pos,
   output logic [slx_pkg::LEN_W-1:0]         rsp_token_length,
   output logic                              rsp_last_of_run
);

   slx_pkg::push_type  push;
   slx_pkg::token_type head;
   logic               room;

   slx_core #(
      .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_byte (req_char_byte),
      .req_is_end    (req_is_end),
      .fifo_room     (room),
      .push          (push)
   );

   slx_token_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   // Drive the result fields from the queue head
   assign rsp_token_kind   = head.kind;
   assign rsp_mantissa     = head.mantissa;
   assign rsp_frac_digits  = head.frac_digits;
   assign rsp_start_pos    = head.start_pos;
   assign rsp_token_length = head.length;
   assign rsp_last_of_run  = head.last;

endmodule

`default_nettype wire

// ===== hw/rtl/slx_checker.sv =====
// Port-level checks for the source code lexer, bound to its top level.
// Depends on slx_pkg and source_code_lexer.
`timescale 1ns / 1ps
`default_nettype none

module slx_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_stall,
   input wire logic [7:0]                   req_char_byte,
   input wire logic                         req_is_end,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_stall,
   input wire logic [slx_pkg::KIND_W-1:0]   rsp_token_kind,
   input wire logic [slx_pkg::MANT_W-1:0]   rsp_mantissa,
   input wire logic [slx_pkg::FRAC_W-1:0]   rsp_frac_digits,
   input wire logic [slx_pkg::POS_W-1:0]    rsp_start_pos,
   input wire logic [slx_pkg::LEN_W-1:0]    rsp_token_length,
   input wire logic                         rsp_last_of_run
);

   // Hold a stalled token beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_token_kind) &&
         $stable(rsp_start_pos) && $stable(rsp_last_of_run))
      else $error("stalled token beat changed");

   // Only number tokens carry a mantissa or fraction count
   a_num_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_token_kind != slx_pkg::TOK_INT) &&
         (rsp_token_kind != slx_pkg::TOK_DECIMAL)
      |-> (rsp_mantissa == '0) && (rsp_frac_digits == '0))
      else $error("non-number token with number fields");

   // Integers have no fraction digits
   a_int_frac: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_token_kind == slx_pkg::TOK_INT) |-> rsp_frac_digits == '0)
      else $error("integer token with fraction digits");

   // End token is empty and closes its beat
   a_end_token: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_token_kind == slx_pkg::TOK_END)
      |-> (rsp_token_length == '0) && rsp_last_of_run)
      else $error("malformed end token");

   // Come out of reset with nothing held on either side
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("lexer not idle after reset");

endmodule

bind source_code_lexer slx_checker u_slx_checker (.*);

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking bench for source_code_lexer: byte stream in, token beats out.
// Depends on slx_pkg for token codes, lexer modes and field widths.
`timescale 1ns / 1ps

import slx_pkg::*;

localparam int KW_DEPTH = KEYWORD_MAX_LEN_DEFAULT;

typedef struct {
   token_kind_type    kind;
   logic [MANT_W-1:0] mant;
   logic [FRAC_W-1:0] frac;
   logic [POS_W-1:0]  start;
   logic [LEN_W-1:0]  len;
   logic              last;
} lex_token_type;

// Tracks lexer state per accepted source beat and holds the tokens still owed
class token_scoreboard;
   lex_mode_type      mode;
   logic [MANT_W-1:0] accum;
   logic              point_seen;
   logic [FRAC_W-1:0] frac_cnt;
   logic [7:0]        word_head [KW_DEPTH];
   logic [LEN_W-1:0]  run_len;
   logic [POS_W-1:0]  byte_pos;
   logic [POS_W-1:0]  tok_start;
   logic [7:0]        op_char;
   lex_token_type     expected_tokens [$];
   lex_token_type     step_tokens [$];
   string             kw_text [6];
   token_kind_type    kw_kind [6];
   int                fail_count;

   function new();
      kw_text = '{"if", "while", "for", "else", "func", "var"};
      kw_kind = '{TOK_KW_IF, TOK_KW_WHILE, TOK_KW_FOR, TOK_KW_ELSE, TOK_KW_FUNC, TOK_KW_VAR};
      fail_count = 0;
      clear_scan();
      byte_pos = '0;
   endfunction

   function void clear_scan();
      mode = MODE_IDLE;
      accum = '0;
      point_seen = 1'b0;
      frac_cnt = '0;
      foreach (word_head[i]) word_head[i] = '0;
      run_len = '0;
      tok_start = '0;
      op_char = '0;
   endfunction

   function bit char_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function bit char_word(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || char_digit(c) || c == "_";
   endfunction

   function bit char_blank(logic [7:0] c);
      return c == " " || c == "\n";
   endfunction

   function logic [7:0] lower(logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

   function token_kind_type char_op(logic [7:0] c);
      case (c)
         "+": return TOK_PLUS;
         "-": return TOK_MINUS;
         "/": return TOK_SLASH;
         "*": return TOK_STAR;
         "=": return TOK_ASSIGN;
         ">": return TOK_GT;
         "<": return TOK_LT;
         "|": return TOK_BOR;
         "&": return TOK_BAND;
         "%": return TOK_PERCENT;
         "!": return TOK_BANG;
         default: return KIND_NONE;
      endcase
   endfunction

   function token_kind_type char_punct(logic [7:0] c);
      case (c)
         "(": return TOK_LPAREN;
         ")": return TOK_RPAREN;
         "{": return TOK_LBRACE;
         "}": return TOK_RBRACE;
         ";": return TOK_SEMI;
         ",": return TOK_COMMA;
         default: return KIND_NONE;
      endcase
   endfunction

   // Two-character operator, or none when the pair does not combine
   function token_kind_type op_pair(logic [7:0] a, logic [7:0] b);
      if (b == "=" && a == "=") return TOK_EQ;
      if (b == "=" && a == "!") return TOK_NE;
      if (b == "=" && a == "<") return TOK_LE;
      if (b == "=" && a == ">") return TOK_GE;
      if (a == b && a == "&") return TOK_LAND;
      if (a == b && a == "|") return TOK_LOR;
      if (a == b && a == "<") return TOK_SHL;
      if (a == b && a == ">") return TOK_SHR;
      return KIND_NONE;
   endfunction

   function bit char_sep(logic [7:0] c);
      return char_op(c) != KIND_NONE || char_punct(c) != KIND_NONE || char_blank(c);
   endfunction

   function logic [LEN_W-1:0] sat_len(logic [LEN_W-1:0] v);
      return (v == LEN_MAX) ? LEN_MAX : v + 1'b1;
   endfunction

   function void add(token_kind_type kind, logic [MANT_W-1:0] mant, logic [FRAC_W-1:0] frac,
                     logic [POS_W-1:0] start, logic [LEN_W-1:0] len);
      lex_token_type t;
      t.kind = kind;
      t.mant = mant;
      t.frac = frac;
      t.start = start;
      t.len = len;
      t.last = 1'b0;
      step_tokens.insert(step_tokens.size(), t);
   endfunction

   // Keyword only on an exact, short enough match followed by a separator
   function void flush_word(bit sep_next);
      token_kind_type kind;
      bit hit;
      kind = TOK_IDENT;
      if (sep_next) begin
         foreach (kw_text[k]) begin
            if (kind == TOK_IDENT && kw_text[k].len() == run_len &&
                kw_text[k].len() <= KW_DEPTH) begin
               hit = 1'b1;
               for (int i = 0; i < kw_text[k].len(); i++) begin
                  if (word_head[i] != kw_text[k][i]) hit = 1'b0;
               end
               if (hit) kind = kw_kind[k];
            end
         end
      end
      add(kind, '0, '0, tok_start, run_len);
   endfunction

   function void flush_number();
      add(point_seen ? TOK_DECIMAL : TOK_INT, accum, point_seen ? frac_cnt : '0,
          tok_start, run_len);
   endfunction

   // Open a new token, or emit a one-byte token, from the idle state
   function void scan_idle(logic [7:0] c);
      token_kind_type pk;
      mode = MODE_IDLE;
      if (char_blank(c)) return;
      tok_start = byte_pos;
      pk = char_punct(c);
      if (char_digit(c)) begin
         mode = MODE_NUM;
         accum = MANT_W'(c - "0");
         point_seen = 1'b0;
         frac_cnt = '0;
         run_len = 1;
      end else if (char_word(c)) begin
         mode = MODE_WORD;
         foreach (word_head[i]) word_head[i] = '0;
         word_head[0] = lower(c);
         run_len = 1;
      end else if (char_op(c) != KIND_NONE) begin
         mode = MODE_OP;
         op_char = c;
      end else if (pk != KIND_NONE) begin
         add(pk, '0, '0, byte_pos, 1);
      end else begin
         add(TOK_ERROR, '0, '0, byte_pos, 1);
      end
   endfunction

   function void scan_byte(logic [7:0] c);
      logic [MANT_W-1:0] d;
      token_kind_type p;
      case (mode)
         MODE_NUM: begin
            if (char_digit(c)) begin
               d = MANT_W'(c - "0");
               if (accum > (MANT_MAX - d) / 10) accum = MANT_MAX;
               else accum = accum * 10 + d;
               if (point_seen && frac_cnt != FRAC_MAX) frac_cnt = frac_cnt + 1'b1;
               run_len = sat_len(run_len);
            end else if (c == "." && !point_seen) begin
               point_seen = 1'b1;
               run_len = sat_len(run_len);
            end else if (char_sep(c)) begin
               flush_number();
               scan_idle(c);
            end else begin
               // bad byte swallows the whole number
               add(TOK_ERROR, '0, '0, tok_start, sat_len(run_len));
               mode = MODE_IDLE;
            end
         end
         MODE_WORD: begin
            if (char_word(c)) begin
               if (run_len < KW_DEPTH) word_head[run_len] = lower(c);
               run_len = sat_len(run_len);
            end else begin
               flush_word(char_sep(c));
               scan_idle(c);
            end
         end
         MODE_OP: begin
            p = op_pair(op_char, c);
            if (p != KIND_NONE) begin
               add(p, '0, '0, tok_start, 2);
               mode = MODE_IDLE;
            end else begin
               add(char_op(op_char), '0, '0, tok_start, 1);
               scan_idle(c);
            end
         end
         default: scan_idle(c);
      endcase
      byte_pos = byte_pos + 1'b1;
   endfunction

   // Predict the tokens of one accepted source beat
   function void note_source(logic [7:0] c, logic fin);
      if (fin) begin
         case (mode)
            MODE_NUM:  flush_number();
            MODE_WORD: flush_word(1'b1);
            MODE_OP:   add(char_op(op_char), '0, '0, tok_start, 1);
            default:   ;
         endcase
         add(TOK_END, '0, '0, byte_pos, 0);
         clear_scan();
         byte_pos = '0;
      end else begin
         scan_byte(c);
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
      foreach (step_tokens[i]) expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
      step_tokens.delete();
   endfunction

   function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: token %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         fail_count++;
      end
   endfunction

   function void check_token(logic [KIND_W-1:0] kind, logic [MANT_W-1:0] mant,
                             logic [FRAC_W-1:0] frac, logic [POS_W-1:0] start,
                             logic [LEN_W-1:0] len, logic last);
      lex_token_type want;
      if (expected_tokens.size() == 0) begin
         $display("%0t: token kind %0d at %0d, expected none, actual beat", $time, kind, start);
         fail_count++;
         return;
      end
      want = expected_tokens.pop_front();
      compare("kind", want.kind, kind);
      compare("mantissa", want.mant, mant);
      compare("frac_digits", want.frac, frac);
      compare("start_pos", want.start, start);
      compare("length", want.len, len);
      compare("last_of_run", want.last, last);
   endfunction

   function int pending();
      return expected_tokens.size();
   endfunction
endclass

module tb_top;
   localparam int RANDOM_BEATS = 510;
   localparam int QUIET_LIMIT  = 3000;
   localparam int HOLD_CYCLES  = 300;

   typedef struct {
      logic [7:0] ch;
      logic       fin;
   } source_beat_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [7:0]        req_char_byte = '0;
   logic              req_is_end = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [KIND_W-1:0] rsp_token_kind;
   logic [MANT_W-1:0] rsp_mantissa;
   logic [FRAC_W-1:0] rsp_frac_digits;
   logic [POS_W-1:0]  rsp_start_pos;
   logic [LEN_W-1:0]  rsp_token_length;
   logic              rsp_last_of_run;

   token_scoreboard token_board = new();
   source_beat_type source_beats [$];
   bit              random_phase = 1'b0;
   int              busy_count = 0;
   string           op_text [19] = '{"+", "-", "/", "*", "=", "==", "!=", "<=", ">=", ">", "<",
                                     "&&", "||", "|", "&", "<<", ">>", "%", "!"};
   string           punct_text = "(){};,";

   source_code_lexer #(.KEYWORD_MAX_LEN(KW_DEPTH)) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_byte    (req_char_byte),
      .req_is_end       (req_is_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_mantissa     (rsp_mantissa),
      .rsp_frac_digits  (rsp_frac_digits),
      .rsp_start_pos    (rsp_start_pos),
      .rsp_token_length (rsp_token_length),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Sample both channels at the edge; inputs before outputs
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) token_board.note_source(req_char_byte, req_is_end);
         if (rsp_valid && !rsp_stall) begin
            token_board.check_token(rsp_token_kind, rsp_mantissa, rsp_frac_digits,
                                    rsp_start_pos, rsp_token_length, rsp_last_of_run);
         end
      end
   end

   function automatic void put_char(logic [7:0] c);
      source_beat_type b;
      b.ch = c;
      b.fin = 1'b0;
      source_beats.insert(source_beats.size(), b);
      if (random_phase) busy_count++;
   endfunction

   function automatic void put_text(string s);
      for (int i = 0; i < s.len(); i++) put_char(s[i]);
   endfunction

   function automatic void put_end();
      source_beat_type b;
      b.ch = 8'($urandom_range(0, 255));
      b.fin = 1'b1;
      source_beats.insert(source_beats.size(), b);
      if (random_phase) busy_count++;
   endfunction

   function automatic logic [7:0] rand_word_char(bit first);
      int r;
      r = $urandom_range(0, first ? 52 : 62);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      if (r == 52) return "_";
      return 8'("0" + r - 53);
   endfunction

   function automatic void put_number(int digits, bit with_point);
      int frac;
      put_char(8'("0" + $urandom_range(0, 9)));
      for (int i = 1; i < digits; i++) put_char(8'("0" + $urandom_range(0, 9)));
      if (with_point) begin
         put_char(".");
         frac = $urandom_range(0, 6);
         for (int i = 0; i < frac; i++) put_char(8'("0" + $urandom_range(0, 9)));
      end
   endfunction

   function automatic void put_word();
      string w;
      int n;
      if ($urandom_range(0, 2) == 0) begin
         // keyword with random letter case
         w = token_board.kw_text[$urandom_range(0, 5)];
         for (int i = 0; i < w.len(); i++) put_char($urandom_range(0, 1) ? w[i] ^ CASE_BIT : w[i]);
      end else begin
         n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 12);
         put_char(rand_word_char(1'b1));
         for (int i = 1; i < n; i++) put_char(rand_word_char(1'b0));
      end
   endfunction

   // One token-shaped piece of source, mostly well formed
   function automatic void put_fragment();
      int r;
      r = $urandom_range(0, 99);
      if (r < 25) begin
         put_word();
      end else if (r < 43) begin
         put_number(($urandom_range(0, 9) == 0) ? $urandom_range(15, 25) : $urandom_range(1, 4),
                    $urandom_range(0, 2) == 0);
      end else if (r < 63) begin
         put_text(op_text[$urandom_range(0, 18)]);
      end else if (r < 77) begin
         put_char(punct_text[$urandom_range(0, 5)]);
      end else if (r < 87) begin
         put_char($urandom_range(0, 1) ? " " : "\n");
      end else if (r < 93) begin
         put_char(8'($urandom_range(0, 255)));
      end else if (r < 97) begin
         // broken sequences: number with a bad tail, word followed by junk
         case ($urandom_range(0, 2))
            0: begin put_number($urandom_range(1, 3), 1'b0); put_char(rand_word_char(1'b1)); end
            1: begin put_number($urandom_range(1, 3), 1'b1); put_char("."); end
            default: begin put_word(); put_char($urandom_range(0, 1) ? "." : 8'h09); end
         endcase
      end else begin
         put_end();
      end
      // separator between pieces so keywords can close
      r = $urandom_range(0, 99);
      if (r < 45) put_char(" ");
      else if (r < 52) put_char("\n");
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   // Offer every queued beat in order and hold each until it is taken
   task automatic drive_beats(bit steady);
      int gap;
      int burst_left;
      burst_left = 0;
      foreach (source_beats[i]) begin
         gap = 0;
         if (!steady && burst_left == 0) begin
            gap = pick_gap();
            if ($urandom_range(0, 29) == 0) burst_left = $urandom_range(20, 60);
         end else if (burst_left > 0) begin
            burst_left--;
         end
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_char_byte <= source_beats[i].ch;
         req_is_end <= source_beats[i].fin;
         @(posedge clock);
         while (req_stall) @(posedge clock);
      end
      source_beats.delete();
   endtask

   initial begin : source_side
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: end from idle, keyword case, keyword ended by junk,
      // bad number byte, decimal, odd bytes, munch of a longer operator,
      // end flushing a pending operator
      put_end();
      put_text("fOr{var.12a3.5;");
      put_char(8'h00);
      put_char(8'hFF);
      put_char(8'h09);
      put_text("<<=");
      put_end();
      drive_beats(1'b0);

      // numeric extremes back to back: exact maximum, first overflow,
      // saturated fraction
      put_text("9223372036854775807 9223372036854775808 1.");
      for (int i = 0; i < 70; i++) put_char("9");
      put_char(",");
      drive_beats(1'b1);

      random_phase = 1'b1;
      while (busy_count < RANDOM_BEATS) put_fragment();
      put_end();
      drive_beats(1'b0);
      req_valid <= 1'b0;

      while (token_board.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (token_board.fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Receiver: random stalls, plus one long hold-off once random traffic starts
   initial begin : token_sink
      int r;
      bit held_off;
      held_off = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (random_phase && !held_off) begin
            held_off = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         r = $urandom_range(0, 99);
         repeat ((r < 80) ? $urandom_range(1, 8) : $urandom_range(30, 100)) @(posedge clock);
         rsp_stall <= 1'b1;
         r = $urandom_range(0, 99);
         if (r < 75) repeat ($urandom_range(1, 3)) @(posedge clock);
         else if (r < 95) repeat ($urandom_range(4, 10)) @(posedge clock);
         else repeat ($urandom_range(20, 60)) @(posedge clock);
      end
   end

   // Abort when neither channel moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("CHECKS FAILED");
      $finish;
   end
endmodule
